[hdl/cht_pkg.sv]
// Shared types and constants for the chained hash table.
package cht_pkg;
    typedef enum logic [1:0] {
        CMD_FIND   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_SPARE  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EXISTS  = 2'd1,
        ST_MISSING = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    localparam int KEY_W       = 31;
    localparam int SIZE_W      = 7;
    localparam int DEFAULT_BKT = 16;
endpackage

[hdl/chained_hash_table_top.sv]
// Chained hash table: top level with bucket hash, chain walk and node pool.
//
// Requests (cmd, key, value) arrive on i_valid / o_stall and results (found,
// value_out, status) leave on o_valid / i_stall. A request is accepted when
// valid is high and stall is low. One request is worked on at a time; o_stall
// stays high from acceptance until its result is loaded into the output register.
// The bucket index is key modulo table_size, found by a restoring subtractor
// one quotient bit per cycle in S_DIV; then S_HEAD reads the bucket head. The
// chain walk passes S_RD and S_CMP for each node compared, including the last
// compare at a match or at the chain end. After it, a find or an insert of an
// existing key goes to S_OUT, a delete through S_DEL, an insert into a full
// pool through S_ALLOC, a successful insert through S_ALLOC and S_INS. S_OUT
// loads the result once the output register is free, and o_valid rises as
// o_stall falls, so the next request can be accepted while the result is shown.
// Writing i_cfg_we empties the table: bucket heads are cleared by a sweep over
// all MAX_BUCKETS heads while no request is accepted. Reset does the same sweep
// and sets table_size to 16.
// When the receiver stalls, the result holds in the output register; one more
// request is worked on and its result waits until the held one is taken.
module chained_hash_table_top #(
    parameter int MAX_BUCKETS = 64,
    parameter int POOL_NODES  = 256,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [6:0]               i_cfg_wdata,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [1:0]               i_cmd,
    input  logic [30:0]              i_key,
    input  logic [VALUE_WIDTH-1:0]   i_value,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic                     o_found,
    output logic [31:0]              o_value_out,
    output logic [1:0]               o_status
);
    import cht_pkg::*;

    localparam int PW = $clog2(POOL_NODES + 1);
    localparam int AW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
    localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int CW = $clog2(POOL_NODES + 1);
    localparam logic [PW-1:0] NIL = PW'(POOL_NODES);
    localparam int HW = (SIZE_W > BW + 1) ? SIZE_W : BW + 1;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DIV, S_HEAD, S_RD, S_CMP, S_ALLOC, S_INS,
        S_DEL, S_OUT
    } t_state;

    logic [KEY_W-1:0]       key_mem [POOL_NODES];
    logic [VALUE_WIDTH-1:0] val_mem [POOL_NODES];
    logic [PW-1:0]          lnk_mem [POOL_NODES];
    logic [PW-1:0]          head_mem [MAX_BUCKETS];

    t_state                 r_state;
    logic [HW-1:0]          r_size;
    logic [BW-1:0]          r_clr;
    logic [1:0]             r_cmd;
    logic [KEY_W-1:0]       r_key;
    logic [VALUE_WIDTH-1:0] r_val;
    logic [HW-1:0]          r_rem;
    logic [4:0]             r_bit;
    logic [BW-1:0]          r_bkt;
    logic [PW-1:0]          r_prev;
    logic [PW-1:0]          r_cur;
    logic [PW-1:0]          r_head;
    logic [KEY_W-1:0]       r_nkey;
    logic [VALUE_WIDTH-1:0] r_nval;
    logic [PW-1:0]          r_nlnk;
    logic [PW-1:0]          r_free;
    logic [CW-1:0]          r_fresh;
    logic [PW-1:0]          r_new;
    logic                   r_ovalid;
    logic                   r_found;
    logic [31:0]            r_vout;
    logic [1:0]             r_status;
    logic                   r_ofound;
    logic [31:0]            r_ovout;
    logic [1:0]             r_ostatus;

    logic [HW:0]            n_rem;
    logic [HW:0]            rem_sh;
    logic [HW-1:0]          sz_eff;
    logic [PW-1:0]          rd_node;
    logic [AW-1:0]          rd_idx;
    logic [PW-1:0]          ln_node;
    logic [AW-1:0]          ln_idx;
    logic                   out_go;

    assign rem_sh = {r_rem, r_key[r_bit]};
    assign n_rem  = (rem_sh >= {1'b0, r_size}) ? rem_sh - {1'b0, r_size} : rem_sh;
    assign sz_eff = (i_cfg_wdata == 7'd0) ? HW'(DEFAULT_BKT) :
                    (HW'(i_cfg_wdata) > HW'(MAX_BUCKETS)) ? HW'(MAX_BUCKETS) :
                    HW'(i_cfg_wdata);

    assign rd_node = (r_state == S_RD) ? ((r_prev == NIL) ? r_head : r_nlnk) : r_cur;
    assign rd_idx  = (rd_node < NIL) ? rd_node[AW-1:0] : '0;
    assign ln_node = (r_state == S_ALLOC) ? r_free : r_cur;
    assign ln_idx  = (ln_node < NIL) ? ln_node[AW-1:0] : '0;
    assign out_go  = !r_ovalid || !i_stall;

    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_ovalid;
    assign o_found     = r_ofound;
    assign o_value_out = r_ovout;
    assign o_status    = r_ostatus;

    always_ff @(posedge i_clk) begin
        r_head <= head_mem[r_bkt];
        r_nkey <= key_mem[rd_idx];
        r_nval <= val_mem[rd_idx];
        r_nlnk <= lnk_mem[ln_idx];
        if (r_state == S_CLEAR) begin
            head_mem[r_clr] <= NIL;
        end
        if (r_state == S_INS) begin
            key_mem[r_new[AW-1:0]] <= r_key;
            val_mem[r_new[AW-1:0]] <= r_val;
            lnk_mem[r_new[AW-1:0]] <= r_head;
            head_mem[r_bkt]        <= r_new;
        end
        if (r_state == S_DEL) begin
            if (r_prev != NIL) begin
                lnk_mem[r_prev[AW-1:0]] <= r_nlnk;
            end else begin
                head_mem[r_bkt] <= r_nlnk;
            end
        end
        if (r_state == S_OUT && out_go && r_cmd == CMD_DELETE && r_found) begin
            lnk_mem[r_cur[AW-1:0]] <= r_free;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_size   <= HW'(DEFAULT_BKT);
            r_clr    <= '0;
            r_free   <= NIL;
            r_fresh  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_state == S_OUT && out_go) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_size  <= sz_eff;
                r_clr   <= '0;
                r_free  <= NIL;
                r_fresh <= '0;
                r_state <= S_CLEAR;
            end else begin
                case (r_state)
                    S_CLEAR: begin
                        r_clr <= r_clr + 1'b1;
                        if (r_clr == BW'(MAX_BUCKETS - 1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                    S_IDLE: begin
                        if (i_valid) begin
                            r_cmd   <= i_cmd;
                            r_key   <= i_key;
                            r_val   <= i_value;
                            r_rem   <= '0;
                            r_bit   <= 5'(KEY_W - 1);
                            r_prev  <= NIL;
                            r_state <= S_DIV;
                        end
                    end
                    S_DIV: begin
                        r_rem <= n_rem[HW-1:0];
                        r_bit <= r_bit - 1'b1;
                        if (r_bit == 5'd0) begin
                            r_bkt   <= BW'(n_rem);
                            r_state <= S_HEAD;
                        end
                    end
                    S_HEAD: begin
                        r_state <= S_RD;
                    end
                    S_RD: begin
                        r_cur   <= rd_node;
                        r_state <= S_CMP;
                    end
                    S_CMP: begin
                        if (r_cur == NIL || r_nkey == r_key) begin
                            r_found  <= (r_cur != NIL);
                            r_vout   <= '0;
                            r_status <= ST_OK;
                            case (r_cmd)
                                CMD_INSERT: begin
                                    if (r_cur != NIL) begin
                                        r_status <= ST_EXISTS;
                                        r_state  <= S_OUT;
                                    end else begin
                                        r_state <= S_ALLOC;
                                    end
                                end
                                CMD_DELETE: begin
                                    if (r_cur != NIL) begin
                                        r_state <= S_DEL;
                                    end else begin
                                        r_status <= ST_MISSING;
                                        r_state  <= S_OUT;
                                    end
                                end
                                default: begin
                                    if (r_cur != NIL) begin
                                        r_vout <= 32'(r_nval);
                                    end else begin
                                        r_status <= ST_MISSING;
                                    end
                                    r_state <= S_OUT;
                                end
                            endcase
                        end else begin
                            r_prev  <= r_cur;
                            r_state <= S_RD;
                        end
                    end
                    S_ALLOC: begin
                        if (r_free != NIL) begin
                            r_new   <= r_free;
                            r_state <= S_INS;
                        end else if (r_fresh < CW'(POOL_NODES)) begin
                            r_new   <= PW'(r_fresh);
                            r_fresh <= r_fresh + 1'b1;
                            r_state <= S_INS;
                        end else begin
                            r_status <= ST_FULL;
                            r_state  <= S_OUT;
                        end
                    end
                    S_INS: begin
                        if (r_new == r_free) begin
                            r_free <= r_nlnk;
                        end
                        r_state <= S_OUT;
                    end
                    S_DEL: begin
                        r_state <= S_OUT;
                    end
                    S_OUT: begin
                        if (out_go) begin
                            r_ofound  <= r_found;
                            r_ovout   <= r_vout;
                            r_ostatus <= r_status;
                            if (r_cmd == CMD_DELETE && r_found) begin
                                r_free <= r_cur;
                            end
                            r_state <= S_IDLE;
                        end
                    end
                    default: r_state <= S_IDLE;
                endcase
            end
        end
    end
endmodule
